// ===== sv/nlpm_pkg.sv =====
package nlpm_pkg;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_NO_OPENER = 3'd2,
    ERR_MISMATCH  = 3'd3,
    ERR_UNCLOSED  = 3'd4
  } err_t;

  localparam int unsigned LineW   = 16;
  localparam int unsigned NumW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 56;

  typedef struct packed {
    logic [LineW-1:0]  line;
    logic [NumW-1:0]   number;
  } entry_t;

  typedef struct packed {
    logic              pair_valid;
    logic [LineW-1:0]  open_line;
    logic [LineW-1:0]  close_line;
    err_t              error_code;
    logic [CountW-1:0] pair_total;
    logic              done_res;
  } result_t;

endpackage

// ===== sv/nested_loop_pair_matcher.sv =====
// Nested loop pair matcher.
// Input stream: one classified program line per item. in_tuser is the line
// kind (ordinary, loop opener, loop closer, end of program); in_tdata holds
// the loop number and the line index. Openers are kept on an on-chip stack
// of NEST_DEPTH entries; each closer pops the top entry and, when the loop
// numbers agree, reports the opener/closer line pair.
// Output stream: exactly one item per input item. out_tuser flags a matched
// pair, out_tlast marks the end-of-program result, out_tdata carries the
// pair lines, the sticky error code and the running pair count.
// out_tvalid follows an accepted item through the input register, then the
// result register; one item is accepted every cycle while the receiver does
// not stall, since a push or pop needs only one number compare.
// Reset clears the stack depth, the pair count, the error and both valid
// flags; stack contents are not cleared. An end-of-program item clears the
// depth, the pair count and the error after its result is formed.
// When the receiver stalls, the result register holds and the input register
// fills; in_tready drops once both are occupied and returns as soon as
// out_tready is seen high.
module nested_loop_pair_matcher #(
  parameter int NEST_DEPTH = 8,
  parameter int MAX_LINES  = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nlpm_pkg::InDataW-1:0]      in_tdata,  // loop_number[31:0], line_index[47:32]
  input  logic [1:0]                        in_tuser,  // kind[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nlpm_pkg::OutDataW-1:0]     out_tdata, // open_line[15:0], close_line[31:16],
                                                       // error_code[34:32], pair_total[50:35]
  output logic                              out_tuser, // pair_valid
  output logic                              out_tlast  // done_res
);

  localparam int DepthW = $clog2(NEST_DEPTH + 1);
  localparam logic [DepthW-1:0] FullDepth = DepthW'(NEST_DEPTH);
  localparam logic [20:0] MaxLinesW = 21'(MAX_LINES);

  logic                                  in_v_r;
  logic [nlpm_pkg::NumW-1:0]             in_num_r;
  logic [nlpm_pkg::LineW-1:0]            in_line_r;
  nlpm_pkg::kind_t                       in_kind_r;

  logic                                  out_v_r;
  nlpm_pkg::result_t                     res_r;
  nlpm_pkg::result_t                     res_nxt;

  nlpm_pkg::entry_t                      stk_r [NEST_DEPTH];
  logic [DepthW-1:0]                     depth_r;
  logic [DepthW-1:0]                     depth_nxt;
  logic [nlpm_pkg::CountW-1:0]           pairs_r;
  logic [nlpm_pkg::CountW-1:0]           pairs_nxt;
  nlpm_pkg::err_t                        fail_r;
  nlpm_pkg::err_t                        fail_nxt;

  logic                                  adv;
  logic                                  fire;
  logic                                  push;
  logic                                  pop;
  nlpm_pkg::kind_t                       kind_eff;

  assign adv       = !out_v_r || out_tready;
  assign fire      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_num_r  <= in_tdata[31:0];
      in_line_r <= in_tdata[47:32];
      in_kind_r <= nlpm_pkg::kind_t'(in_tuser);
    end
  end

  always_comb begin
    kind_eff = in_kind_r;
    if (({5'b0, in_line_r} >= MaxLinesW) && (in_kind_r != nlpm_pkg::KIND_END)) begin
      kind_eff = nlpm_pkg::KIND_PLAIN;
    end
  end

  always_comb begin
    depth_nxt = depth_r;
    pairs_nxt = pairs_r;
    fail_nxt  = fail_r;
    push      = 1'b0;
    pop       = 1'b0;
    res_nxt   = '0;
    if (fail_r == nlpm_pkg::ERR_NONE) begin
      unique case (kind_eff)
        nlpm_pkg::KIND_OPEN: begin
          if (depth_r == FullDepth) begin
            fail_nxt = nlpm_pkg::ERR_OVERFLOW;
          end else begin
            push      = 1'b1;
            depth_nxt = depth_r + 1'b1;
          end
        end
        nlpm_pkg::KIND_CLOSE: begin
          if (depth_r == '0) begin
            fail_nxt = nlpm_pkg::ERR_NO_OPENER;
          end else begin
            pop       = 1'b1;
            depth_nxt = depth_r - 1'b1;
            if (stk_r[0].number != in_num_r) begin
              fail_nxt = nlpm_pkg::ERR_MISMATCH;
            end else begin
              res_nxt.pair_valid = 1'b1;
              res_nxt.open_line  = stk_r[0].line;
              res_nxt.close_line = in_line_r;
              if (pairs_r != '1) begin
                pairs_nxt = pairs_r + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (kind_eff == nlpm_pkg::KIND_END) begin
      res_nxt.done_res = 1'b1;
      if (fail_r == nlpm_pkg::ERR_NONE && depth_r != '0) begin
        fail_nxt = nlpm_pkg::ERR_UNCLOSED;
      end
    end
    res_nxt.error_code = fail_nxt;
    res_nxt.pair_total = pairs_nxt;
    if (kind_eff == nlpm_pkg::KIND_END) begin
      depth_nxt = '0;
      pairs_nxt = '0;
      fail_nxt  = nlpm_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      pairs_r <= '0;
      fail_r  <= nlpm_pkg::ERR_NONE;
    end else if (fire) begin
      depth_r <= depth_nxt;
      pairs_r <= pairs_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // stack as a shift line: entry 0 is the top
  always_ff @(posedge clk) begin
    if (fire && push) begin
      stk_r[0].line   <= in_line_r;
      stk_r[0].number <= in_num_r;
      for (int i = 1; i < NEST_DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (fire && pop) begin
      for (int i = 0; i < NEST_DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.pair_valid;
  assign out_tlast  = res_r.done_res;
  assign out_tdata  = {5'b0, res_r.pair_total, res_r.error_code,
                       res_r.close_line, res_r.open_line};

endmodule

// ===== sv/nlpm_checker.sv =====
module nlpm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_pair_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[34:32] == 3'd0)
    else $error("pair reported with error set");

  a_pair_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast)
    else $error("pair on end of program result");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:32] == 3'd0 || out_tdata[34:32] == 3'd1
      || out_tdata[34:32] == 3'd2 || out_tdata[34:32] == 3'd3
      || out_tdata[34:32] == 3'd4))
    else $error("error code out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind nested_loop_pair_matcher nlpm_checker u_nlpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
